@@ rtl/core/vssb_pkg.sv @@
// package for the versioned speculative store buffer
// shared types, sizes and codes; no dependencies
package vssb_pkg;
  localparam int ENTRIES = 16;
  localparam int VERSIONS = 8;
  localparam int ADDR_BITS = 32;
  localparam int VERSION_BITS = 16;
  localparam int SLOT_W = $clog2(ENTRIES);
  localparam int HIST_W = $clog2(VERSIONS);
  localparam int CNT_W = $clog2(VERSIONS + 1);
  localparam int MEM_W = $clog2(ENTRIES * VERSIONS);

  localparam logic [2:0] OP_WRITE = 3'd0;
  localparam logic [2:0] OP_READ = 3'd1;
  localparam logic [2:0] OP_COMMIT = 3'd2;
  localparam logic [2:0] OP_FREEZE = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;
  localparam logic [2:0] OP_CLRRANGE = 3'd5;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_MISS = 3'd1;
  localparam logic [2:0] ST_TFULL = 3'd2;
  localparam logic [2:0] ST_HFULL = 3'd3;
  localparam logic [2:0] ST_AHEAD = 3'd4;
  localparam logic [2:0] ST_SAT = 3'd5;

  typedef struct packed {
    logic [2:0] opcode;
    logic [31:0] address;
    logic [31:0] write_value;
    logic [15:0] commit_version;
    logic [31:0] range_begin;
    logic [31:0] range_end;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [31:0] read_value;
    logic writeback_valid;
    logic [31:0] writeback_address;
    logic [31:0] writeback_value;
    logic last;
    logic [15:0] version_now;
  } rsp_t;
endpackage

@@ rtl/core/vssb_req_if.sv @@
// request channel interface
// depends on vssb_pkg
interface vssb_req_if import vssb_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/vssb_rsp_if.sv @@
// result channel interface
// depends on vssb_pkg
interface vssb_rsp_if import vssb_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/versioned_speculative_store_buffer_core.sv @@
// versioned speculative store buffer, top level
// depends on vssb_pkg, vssb_req_if, vssb_rsp_if
//
// channel | direction | payload
// in_req  | sink      | opcode address write_value commit_version range_*
// out_rsp | source    | status read_value writeback_* last version_now
//
// one request at a time; a single slot unit walks the slots one per cycle
// for read, write and clear range; commit may search and shift each slot's
// history in the history memory. reset clears slot valid bits and counts
// at once. a stalled result holds the commit walk until it is taken.
module versioned_speculative_store_buffer_core
  import vssb_pkg::*;
(
  input logic clk,
  input logic rst_n,
  vssb_req_if.sink in_req,
  vssb_rsp_if.source out_rsp
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;
  localparam logic [3:0] S_RD = 4'd2;
  localparam logic [3:0] S_RDW = 4'd3;
  localparam logic [3:0] S_WR = 4'd4;
  localparam logic [3:0] S_OUT = 4'd5;
  localparam logic [3:0] S_CSLOT = 4'd6;
  localparam logic [3:0] S_CSRCH = 4'd7;
  localparam logic [3:0] S_CSRW = 4'd8;
  localparam logic [3:0] S_CMOVE = 4'd9;
  localparam logic [3:0] S_CMOVW = 4'd10;
  localparam logic [3:0] S_CEMIT = 4'd11;
  localparam logic [3:0] S_CEND = 4'd12;

  logic [3:0] state_r;
  req_t req_r;
  logic [ENTRIES-1:0] valid_r;
  logic [ADDR_BITS-1:0] addr_r [ENTRIES];
  logic [CNT_W-1:0] cnt_r [ENTRIES];
  logic [VERSION_BITS-1:0] cur_r;
  logic [VERSION_BITS-1:0] hver_m [ENTRIES*VERSIONS];
  logic [31:0] hval_m [ENTRIES*VERSIONS];
  logic [VERSION_BITS-1:0] rd_ver_r;
  logic [31:0] rd_val_r;
  logic [31:0] wb_val_r;
  logic [SLOT_W:0] idx_r;
  logic [SLOT_W:0] hit_r, free_r;
  logic [CNT_W-1:0] h_r, j_r;
  logic found_r, any_r, pend_r;
  rsp_t rsp_r, pend_rsp_r;
  rsp_t init_rsp, last_rsp;
  logic out_v_r;

  logic mem_we, mem_re;
  logic [MEM_W-1:0] mem_wa, mem_ra;
  logic [VERSION_BITS-1:0] mem_wver;
  logic [31:0] mem_wval;
  logic wval_only;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      if (!wval_only) hver_m[mem_wa] <= mem_wver;
      hval_m[mem_wa] <= mem_wval;
    end
    if (mem_re) begin
      rd_ver_r <= hver_m[mem_ra];
      rd_val_r <= hval_m[mem_ra];
    end
  end

  function automatic logic [MEM_W-1:0] maddr(input logic [SLOT_W-1:0] s,
                                             input logic [CNT_W-1:0] h);
    logic [MEM_W+CNT_W-1:0] t;
    t = (MEM_W+CNT_W)'(s) * (MEM_W+CNT_W)'(VERSIONS) + (MEM_W+CNT_W)'(h);
    return t[MEM_W-1:0];
  endfunction

  logic [SLOT_W-1:0] si, sh;
  logic out_free;
  logic out_load;
  assign si = idx_r[SLOT_W-1:0];
  assign sh = hit_r[SLOT_W-1:0];
  assign out_free = !out_v_r || out_rsp.ready;
  assign out_load = out_free && ((state_r == S_OUT) || (state_r == S_CEND)
                                 || (state_r == S_CEMIT && pend_r));
  assign in_req.ready = (state_r == S_IDLE) && !out_v_r;
  assign out_rsp.valid = out_v_r;
  assign out_rsp.data = rsp_r;

  // first result of a request
  always_comb begin
    init_rsp = '0;
    init_rsp.last = 1'b1;
    init_rsp.version_now = cur_r;
    unique case (in_req.data.opcode)
      OP_COMMIT: begin
        if (in_req.data.commit_version > cur_r) init_rsp.status = ST_AHEAD;
      end
      OP_FREEZE: begin
        if (cur_r == '1) init_rsp.status = ST_SAT;
        else init_rsp.version_now = cur_r + VERSION_BITS'(1);
      end
      OP_CLEAR: init_rsp.version_now = '0;
      default: ;
    endcase
  end

  always_comb begin
    last_rsp = pend_rsp_r;
    last_rsp.last = 1'b1;
  end

  // memory port control
  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_wa = '0;
    mem_ra = '0;
    mem_wver = cur_r;
    mem_wval = req_r.write_value;
    wval_only = 1'b0;
    unique case (state_r)
      S_SCAN: begin
        if (idx_r == (SLOT_W+1)'(ENTRIES) && hit_r != (SLOT_W+1)'(ENTRIES)
            && cnt_r[sh] != '0) begin
          mem_re = 1'b1;
          mem_ra = maddr(sh, cnt_r[sh] - CNT_W'(1));
        end
      end
      S_CSLOT: begin
        if (idx_r != (SLOT_W+1)'(ENTRIES) && valid_r[si] && cnt_r[si] != '0) begin
          mem_re = 1'b1;
          mem_ra = maddr(si, cnt_r[si] - CNT_W'(1));
        end
      end
      S_CSRW: begin
        if (!(rd_ver_r <= req_r.commit_version) && h_r > CNT_W'(1)) begin
          mem_re = 1'b1;
          mem_ra = maddr(si, h_r - CNT_W'(2));
        end
      end
      S_CMOVE: begin
        if (j_r < cnt_r[si]) begin
          mem_re = 1'b1;
          mem_ra = maddr(si, j_r);
        end
      end
      S_CMOVW: begin
        mem_we = 1'b1;
        mem_wa = maddr(si, j_r - h_r - CNT_W'(1));
        mem_wver = (j_r - CNT_W'(1) == h_r) ? req_r.commit_version : rd_ver_r;
        mem_wval = rd_val_r;
      end
      S_WR: begin
        mem_we = 1'b1;
        if (hit_r == (SLOT_W+1)'(ENTRIES)) mem_wa = maddr(free_r[SLOT_W-1:0], '0);
        else if (found_r) begin
          mem_wa = maddr(sh, cnt_r[sh] - CNT_W'(1));
          wval_only = 1'b1;
        end else mem_wa = maddr(sh, cnt_r[sh]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      for (int i = 0; i < ENTRIES; i++) cnt_r[i] <= '0;
      cur_r <= '0;
      out_v_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      if (out_load) out_v_r <= 1'b1;
      else if (out_rsp.ready) out_v_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_req.valid && in_req.ready) begin
            req_r <= in_req.data;
            idx_r <= '0;
            hit_r <= (SLOT_W+1)'(ENTRIES);
            free_r <= (SLOT_W+1)'(ENTRIES);
            any_r <= 1'b0;
            pend_r <= 1'b0;
            rsp_r <= init_rsp;
            unique case (in_req.data.opcode) inside
              OP_WRITE, OP_READ, OP_CLRRANGE: state_r <= S_SCAN;
              OP_COMMIT: begin
                if (in_req.data.commit_version > cur_r) state_r <= S_OUT;
                else state_r <= S_CSLOT;
              end
              OP_FREEZE: begin
                if (cur_r != '1) cur_r <= cur_r + VERSION_BITS'(1);
                state_r <= S_OUT;
              end
              OP_CLEAR: begin
                valid_r <= '0;
                for (int i = 0; i < ENTRIES; i++) cnt_r[i] <= '0;
                cur_r <= '0;
                state_r <= S_OUT;
              end
              default: state_r <= S_OUT;
            endcase
          end
        end
        S_SCAN: begin
          if (idx_r != (SLOT_W+1)'(ENTRIES)) begin
            if (req_r.opcode == OP_CLRRANGE) begin
              if (valid_r[si] && req_r.range_begin <= addr_r[si]
                  && addr_r[si] < req_r.range_end) begin
                valid_r[si] <= 1'b0;
                cnt_r[si] <= '0;
              end
            end else begin
              if (valid_r[si] && addr_r[si] == req_r.address
                  && hit_r == (SLOT_W+1)'(ENTRIES)) hit_r <= idx_r;
              if (!valid_r[si] && free_r == (SLOT_W+1)'(ENTRIES)) free_r <= idx_r;
            end
            idx_r <= idx_r + (SLOT_W+1)'(1);
          end else if (req_r.opcode == OP_CLRRANGE) state_r <= S_OUT;
          else if (req_r.opcode == OP_READ) begin
            if (hit_r == (SLOT_W+1)'(ENTRIES) || cnt_r[sh] == '0) begin
              rsp_r.status <= ST_MISS;
              state_r <= S_OUT;
            end else state_r <= S_RDW;
          end else begin
            if (hit_r == (SLOT_W+1)'(ENTRIES)) begin
              if (free_r == (SLOT_W+1)'(ENTRIES)) begin
                rsp_r.status <= ST_TFULL;
                state_r <= S_OUT;
              end else state_r <= S_WR;
            end else if (cnt_r[sh] != '0) state_r <= S_RDW;
            else if (cnt_r[sh] >= CNT_W'(VERSIONS)) begin
              rsp_r.status <= ST_HFULL;
              state_r <= S_OUT;
            end else begin
              found_r <= 1'b0;
              state_r <= S_WR;
            end
          end
        end
        S_RDW: begin
          if (req_r.opcode == OP_READ) begin
            rsp_r.read_value <= rd_val_r;
            state_r <= S_OUT;
          end else if (rd_ver_r == cur_r) begin
            found_r <= 1'b1;
            state_r <= S_WR;
          end else if (cnt_r[sh] >= CNT_W'(VERSIONS)) begin
            rsp_r.status <= ST_HFULL;
            state_r <= S_OUT;
          end else begin
            found_r <= 1'b0;
            state_r <= S_WR;
          end
        end
        S_WR: begin
          if (hit_r == (SLOT_W+1)'(ENTRIES)) begin
            valid_r[free_r[SLOT_W-1:0]] <= 1'b1;
            addr_r[free_r[SLOT_W-1:0]] <= req_r.address;
            cnt_r[free_r[SLOT_W-1:0]] <= CNT_W'(1);
          end else if (!found_r) cnt_r[sh] <= cnt_r[sh] + CNT_W'(1);
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) state_r <= S_IDLE;
        end
        // commit walk
        S_CSLOT: begin
          if (idx_r == (SLOT_W+1)'(ENTRIES)) state_r <= S_CEND;
          else if (!valid_r[si] || cnt_r[si] == '0) idx_r <= idx_r + (SLOT_W+1)'(1);
          else begin
            h_r <= cnt_r[si];
            state_r <= S_CSRW;
          end
        end
        S_CSRW: begin
          if (req_r.commit_version == cur_r) state_r <= S_CEMIT;
          else if (rd_ver_r <= req_r.commit_version) begin
            h_r <= h_r - CNT_W'(1);
            j_r <= h_r - CNT_W'(1);
            state_r <= S_CMOVE;
          end else if (h_r > CNT_W'(1)) h_r <= h_r - CNT_W'(1);
          else begin
            idx_r <= idx_r + (SLOT_W+1)'(1);
            state_r <= S_CSLOT;
          end
        end
        S_CMOVE: begin
          if (j_r < cnt_r[si]) begin
            j_r <= j_r + CNT_W'(1);
            state_r <= S_CMOVW;
          end else begin
            cnt_r[si] <= cnt_r[si] - h_r;
            state_r <= S_CEMIT;
          end
        end
        S_CMOVW: begin
          if (j_r - CNT_W'(1) == h_r) wb_val_r <= rd_val_r;
          state_r <= S_CMOVE;
        end
        S_CEMIT: begin
          if (out_free) begin
            if (pend_r) rsp_r <= pend_rsp_r;
            pend_r <= 1'b1;
            any_r <= 1'b1;
            pend_rsp_r.status <= ST_OK;
            pend_rsp_r.read_value <= '0;
            pend_rsp_r.writeback_valid <= 1'b1;
            pend_rsp_r.writeback_address <= addr_r[si];
            pend_rsp_r.writeback_value <= (req_r.commit_version == cur_r) ? rd_val_r
                                                                         : wb_val_r;
            pend_rsp_r.last <= 1'b0;
            pend_rsp_r.version_now <= cur_r;
            idx_r <= idx_r + (SLOT_W+1)'(1);
            state_r <= S_CSLOT;
          end
        end
        S_CEND: begin
          if (out_free) begin
            if (any_r) rsp_r <= last_rsp;
            if (req_r.commit_version == cur_r) begin
              valid_r <= '0;
              for (int i = 0; i < ENTRIES; i++) cnt_r[i] <= '0;
            end
            pend_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> state_r != S_IDLE || out_v_r)
    else $error("request accepted without work");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_rsp.ready |=> out_v_r)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !pend_r)
    else $error("commit left a pending result");
endmodule

@@ verif/vssb_req_if.sv @@
// request channel interface, testbench copy is not needed; see rtl
// this file intentionally mirrors nothing
// no dependencies

@@ verif/versioned_speculative_store_buffer_core_test.sv @@
// testbench for the versioned speculative store buffer core
// drives random and directed requests, predicts results with its own model
// depends on vssb_pkg, vssb_req_if, vssb_rsp_if and the core
module versioned_speculative_store_buffer_core_test import vssb_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH = 256;

  class buffer_scoreboard;
    bit sv[ENTRIES];
    logic [31:0] sa[ENTRIES];
    int cnt[ENTRIES];
    logic [15:0] hs[ENTRIES][VERSIONS];
    logic [31:0] hv[ENTRIES][VERSIONS];
    logic [15:0] ver;
    rsp_t exp_q[QDEPTH];
    int head;
    int tail;
    int errors;
    int checked;

    function void clear_slots();
      foreach (sv[i]) begin
        sv[i] = 0;
        cnt[i] = 0;
      end
    endfunction

    function int waiting();
      return tail - head;
    endfunction

    function void push(logic [2:0] st, logic [31:0] rv, bit wv, logic [31:0] wa,
                       logic [31:0] wd, bit lst);
      rsp_t r;
      r.status = st;
      r.read_value = rv;
      r.writeback_valid = wv;
      r.writeback_address = wa;
      r.writeback_value = wd;
      r.last = lst;
      r.version_now = ver;
      exp_q[tail % QDEPTH] = r;
      tail++;
    endfunction

    function int find(logic [31:0] a);
      for (int s = 0; s < ENTRIES; s++)
        if (sv[s] && sa[s] == a) return s;
      return -1;
    endfunction

    function logic [2:0] store(logic [31:0] a, logic [31:0] v);
      int s;
      int n;
      s = find(a);
      if (s < 0) begin
        for (s = 0; s < ENTRIES; s++)
          if (!sv[s]) break;
        if (s >= ENTRIES) return ST_TFULL;
        sv[s] = 1;
        sa[s] = a;
        cnt[s] = 1;
        hs[s][0] = ver;
        hv[s][0] = v;
        return ST_OK;
      end
      n = cnt[s];
      if (n > 0 && hs[s][n-1] == ver) begin
        hv[s][n-1] = v;
        return ST_OK;
      end
      if (n >= VERSIONS) return ST_HFULL;
      hs[s][n] = ver;
      hv[s][n] = v;
      cnt[s] = n + 1;
      return ST_OK;
    endfunction

    function void commit(logic [15:0] cv);
      int k;
      int h;
      int n;
      bit found;
      k = 0;
      if (cv > ver) begin
        push(ST_AHEAD, 0, 0, 0, 0, 1);
        return;
      end
      for (int s = 0; s < ENTRIES; s++) begin
        n = cnt[s];
        if (!sv[s] || n == 0) continue;
        found = 0;
        if (cv == ver) begin
          h = n - 1;
          found = 1;
        end else begin
          for (h = n; h > 0; h--)
            if (hs[s][h-1] <= cv) begin
              found = 1;
              break;
            end
          if (!found) continue;
          h--;
          hs[s][h] = cv;
          for (int j = h; j < n; j++) begin
            hs[s][j-h] = hs[s][j];
            hv[s][j-h] = hv[s][j];
          end
          cnt[s] = n - h;
          h = 0;
        end
        push(ST_OK, 0, 1, sa[s], hv[s][h], 0);
        k++;
      end
      if (cv == ver) clear_slots();
      if (k == 0) push(ST_OK, 0, 0, 0, 0, 1);
      else exp_q[(tail - 1) % QDEPTH].last = 1;
    endfunction

    function void note_request(req_t q);
      logic [2:0] st;
      logic [31:0] rv;
      int s;
      st = ST_OK;
      rv = 0;
      case (q.opcode)
        OP_WRITE: st = store(q.address, q.write_value);
        OP_READ: begin
          s = find(q.address);
          if (s < 0 || cnt[s] == 0) st = ST_MISS;
          else rv = hv[s][cnt[s]-1];
        end
        OP_COMMIT: begin
          commit(q.commit_version);
          return;
        end
        OP_FREEZE: begin
          if (ver == 16'hffff) st = ST_SAT;
          else ver++;
        end
        OP_CLEAR: begin
          clear_slots();
          ver = 0;
        end
        OP_CLRRANGE: begin
          for (s = 0; s < ENTRIES; s++)
            if (sv[s] && q.range_begin <= sa[s] && sa[s] < q.range_end) begin
              sv[s] = 0;
              cnt[s] = 0;
            end
        end
        default: ;
      endcase
      push(st, rv, 0, 0, 0, 1);
    endfunction

    function void check_result(rsp_t r);
      rsp_t e;
      checked++;
      if (waiting() == 0) begin
        $error("unexpected result status %0d", r.status);
        errors++;
        return;
      end
      e = exp_q[head % QDEPTH];
      head++;
      if (r.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, r.status); errors++;
      end
      if (r.read_value !== e.read_value) begin
        $error("read_value exp %h got %h", e.read_value, r.read_value); errors++;
      end
      if (r.writeback_valid !== e.writeback_valid) begin
        $error("writeback_valid exp %b got %b", e.writeback_valid, r.writeback_valid);
        errors++;
      end
      if (r.writeback_address !== e.writeback_address) begin
        $error("writeback_address exp %h got %h", e.writeback_address,
               r.writeback_address);
        errors++;
      end
      if (r.writeback_value !== e.writeback_value) begin
        $error("writeback_value exp %h got %h", e.writeback_value, r.writeback_value);
        errors++;
      end
      if (r.last !== e.last) begin
        $error("last exp %b got %b", e.last, r.last); errors++;
      end
      if (r.version_now !== e.version_now) begin
        $error("version_now exp %0d got %0d", e.version_now, r.version_now); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  vssb_req_if in_req ();
  vssb_rsp_if out_rsp ();
  buffer_scoreboard board;
  bit calm = 0;
  int sent = 0;
  logic [31:0] pool[8];

  versioned_speculative_store_buffer_core u_dut (
    .clk(clk), .rst_n(rst_n), .in_req(in_req.sink), .out_rsp(out_rsp.source)
  );

  always #5 clk = ~clk;

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_rsp.valid && out_rsp.ready) board.check_result(out_rsp.data);
  end

  // result side stalls in bursts
  initial begin
    int gap;
    out_rsp.ready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_rsp.ready <= 0;
        gap = $urandom_range(1, 11);
        repeat (gap) @(negedge clk);
      end
      out_rsp.ready <= 1;
    end
  end

  task automatic send(req_t q);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_req.valid <= 0;
      gap = $urandom_range(1, 11);
      repeat (gap) @(negedge clk);
    end
    in_req.data <= q;
    in_req.valid <= 1;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    board.note_request(q);
    sent++;
    @(negedge clk);
  endtask

  function automatic req_t blank(logic [2:0] op);
    req_t q;
    q.opcode = op;
    q.address = $urandom();
    q.write_value = $urandom();
    q.commit_version = 16'($urandom());
    q.range_begin = $urandom();
    q.range_end = $urandom();
    return q;
  endfunction

  task automatic op_write(logic [31:0] a, logic [31:0] v);
    req_t q;
    q = blank(OP_WRITE);
    q.address = a;
    q.write_value = v;
    send(q);
  endtask

  task automatic op_simple(logic [2:0] op, logic [31:0] a);
    req_t q;
    q = blank(op);
    q.address = a;
    send(q);
  endtask

  task automatic op_commit(logic [15:0] cv);
    req_t q;
    q = blank(OP_COMMIT);
    q.commit_version = cv;
    send(q);
  endtask

  task automatic op_range(logic [31:0] b, logic [31:0] e);
    req_t q;
    q = blank(OP_CLRRANGE);
    q.range_begin = b;
    q.range_end = e;
    send(q);
  endtask

  function automatic logic [31:0] pick_addr();
    return ($urandom_range(0, 9) == 0) ? $urandom() : pool[$urandom_range(0, 7)];
  endfunction

  initial begin
    int r;
    board = new();
    board.clear_slots();
    board.ver = 0;
    in_req.valid = 0;
    in_req.data = '0;
    foreach (pool[i]) pool[i] = $urandom();
    pool[0] = 0;
    pool[1] = 32'hffffffff;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed part
    op_simple(OP_READ, 0);
    op_write(0, 32'hffffffff);
    op_write(32'hffffffff, 0);
    op_simple(OP_READ, 0);
    op_commit(1);
    op_commit(0);
    op_commit(0);
    for (int i = 0; i < 17; i++) op_write(i * 3, i);
    for (int i = 0; i < 8; i++) begin
      op_simple(OP_FREEZE, 0);
      op_write(3, i);
    end
    op_simple(OP_READ, 3);
    op_commit(4);
    op_range(10, 5);
    op_range(0, 32'hffffffff);
    op_simple(3'd6, 0);
    op_simple(3'd7, 0);
    op_simple(OP_CLEAR, 0);

    // random part
    for (int i = 0; i < 360; i++) begin
      if (i > 320) calm = 1;
      r = $urandom_range(0, 99);
      if (r < 40) op_write(pick_addr(), $urandom());
      else if (r < 60) op_simple(OP_READ, pick_addr());
      else if (r < 70) op_simple(OP_FREEZE, 0);
      else if (r < 80) op_commit(16'(board.ver - 16'($urandom_range(0, 3))));
      else if (r < 83) op_commit(16'(board.ver + 16'($urandom_range(0, 2))));
      else if (r < 86) op_commit(16'($urandom()));
      else if (r < 88) op_simple(OP_CLEAR, 0);
      else if (r < 92) op_range(pick_addr(), pick_addr());
      else if (r < 94) op_simple(3'($urandom_range(6, 7)), $urandom());
      else op_write($urandom(), $urandom());
    end

    calm = 1;
    in_req.valid <= 0;
    while (board.waiting() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d requests, checked %0d results, final version %0d",
             sent, board.checked, board.ver);
    if (board.errors == 0 && board.waiting() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
